// ===== hw/rtl/tcw_pkg.sv =====
package tcw_pkg;

    // field widths
    localparam int COL_W = 7;
    localparam int ROW_W = 5;
    localparam int LIN_W = 12;
    localparam int OUT_LIN_W = 11;

    // request codes
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    // console byte codes
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_M      = 8'h6D;

    // attributes
    localparam logic [7:0] ATTR_DEFAULT = 8'h07;
    localparam logic [15:0] CELL_BLANK  = {ATTR_DEFAULT, 8'h00};

    // sgr code bases
    localparam logic [7:0] SGR_FG     = 8'd30;
    localparam logic [7:0] SGR_FG_HI  = 8'd90;
    localparam logic [7:0] SGR_BG     = 8'd40;
    localparam logic [7:0] SGR_BG_HI  = 8'd100;
    localparam logic [7:0] SGR_RESET  = 8'd0;

    // work the back end carries out for one word
    typedef enum logic [2:0] {
        OP_NOP     = 3'd0,
        OP_PRINT   = 3'd1,
        OP_NEWLINE = 3'd2,
        OP_CR      = 3'd3,
        OP_TAB     = 3'd4,
        OP_READ    = 3'd5,
        OP_CLEAR   = 3'd6
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [7:0]       ch;
        logic [7:0]       attr;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } t_cmd;

    // ansi color index to vga nibble
    function automatic logic [3:0] ansi_color(input logic [3:0] idx);
        logic [3:0] c;
        case (idx)
            4'd0:    c = 4'h0;
            4'd1:    c = 4'h4;
            4'd2:    c = 4'h2;
            4'd3:    c = 4'h6;
            4'd4:    c = 4'h1;
            4'd5:    c = 4'h5;
            4'd6:    c = 4'h3;
            4'd7:    c = 4'h7;
            4'd8:    c = 4'h8;
            4'd9:    c = 4'hC;
            4'd10:   c = 4'hA;
            4'd11:   c = 4'hE;
            4'd12:   c = 4'h9;
            4'd13:   c = 4'hD;
            4'd14:   c = 4'hB;
            default: c = 4'hF;
        endcase
        return c;
    endfunction

    // apply one sgr code to an attribute
    function automatic logic [7:0] sgr_apply(input logic [7:0] attr, input logic [7:0] code);
        logic [7:0] res;
        logic [7:0] d_fg;
        logic [7:0] d_fgh;
        logic [7:0] d_bg;
        logic [7:0] d_bgh;
        d_fg  = code - SGR_FG;
        d_fgh = code - SGR_FG_HI;
        d_bg  = code - SGR_BG;
        d_bgh = code - SGR_BG_HI;
        res   = attr;
        if (code >= SGR_FG && code < SGR_FG + 8'd8)
            res = {attr[7:4], ansi_color({1'b0, d_fg[2:0]})};
        else if (code >= SGR_FG_HI && code < SGR_FG_HI + 8'd8)
            res = {attr[7:4], ansi_color({1'b1, d_fgh[2:0]})};
        else if (code >= SGR_BG && code < SGR_BG + 8'd8)
            res = {ansi_color({1'b0, d_bg[2:0]}), attr[3:0]};
        else if (code >= SGR_BG_HI && code < SGR_BG_HI + 8'd8)
            res = {ansi_color({1'b1, d_bgh[2:0]}), attr[3:0]};
        else if (code == SGR_RESET)
            res = ATTR_DEFAULT;
        return res;
    endfunction

endpackage

// ===== hw/rtl/tcw_front.sv =====
module tcw_front
    import tcw_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_full,
    input  logic [1:0]       i_req_type,
    input  logic [7:0]       i_data_byte,
    input  logic [COL_W-1:0] i_cell_col,
    input  logic [ROW_W-1:0] i_cell_row,
    output logic             o_push,
    output t_cmd             o_cmd
);

    typedef enum logic [2:0] {
        PM_NORMAL = 3'b001,
        PM_ESC    = 3'b010,
        PM_PARAM  = 3'b100
    } t_pmode;

    t_pmode     r_mode;
    t_pmode     n_mode;
    logic [7:0] r_accum;
    logic [7:0] n_accum;
    logic [7:0] r_attr;
    logic [7:0] n_attr;
    logic       plain;
    logic [7:0] b;

    assign b      = i_data_byte;
    assign o_push = i_start & ~i_full;

    // parse the escape state and classify the word
    always_comb begin
        n_mode     = r_mode;
        n_accum    = r_accum;
        n_attr     = r_attr;
        plain      = 1'b0;
        o_cmd.op   = OP_NOP;
        o_cmd.ch   = b;
        o_cmd.col  = i_cell_col;
        o_cmd.row  = i_cell_row;
        case (i_req_type)
            REQ_WRITE: begin
                unique case (r_mode)
                    PM_ESC: begin
                        if (b == CH_LBRACK) begin
                            n_mode  = PM_PARAM;
                            n_accum = 8'd0;
                        end else if (b != CH_ESC) begin
                            n_mode = PM_NORMAL;
                            plain  = 1'b1;
                        end
                    end
                    PM_PARAM: begin
                        if (b >= CH_0 && b <= CH_9) begin
                            n_accum = 8'(r_accum * 8'd10 + (b - CH_0));
                        end else if (b == CH_SEMI) begin
                            n_attr  = sgr_apply(r_attr, r_accum);
                            n_accum = 8'd0;
                        end else if (b == CH_M) begin
                            n_attr  = sgr_apply(r_attr, r_accum);
                            n_accum = 8'd0;
                            n_mode  = PM_NORMAL;
                        end
                    end
                    PM_NORMAL: plain = 1'b1;
                    default:   n_mode = PM_NORMAL;
                endcase
                if (plain) begin
                    if (b == CH_ESC)
                        n_mode = PM_ESC;
                    else if (b == CH_LF)
                        o_cmd.op = OP_NEWLINE;
                    else if (b == CH_CR)
                        o_cmd.op = OP_CR;
                    else if (b == CH_TAB)
                        o_cmd.op = OP_TAB;
                    else
                        o_cmd.op = OP_PRINT;
                end
            end
            REQ_READ:  o_cmd.op = OP_READ;
            REQ_CLEAR: o_cmd.op = OP_CLEAR;
            default:   o_cmd.op = OP_NOP;
        endcase
        o_cmd.attr = n_attr;
    end

    // parser registers advance on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= PM_NORMAL;
            r_accum <= 8'd0;
            r_attr  <= ATTR_DEFAULT;
        end else if (o_push) begin
            r_mode  <= n_mode;
            r_accum <= n_accum;
            r_attr  <= n_attr;
        end
    end

endmodule

// ===== hw/rtl/tcw_fifo.sv =====
module tcw_fifo
    import tcw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    input  logic i_pop,
    output t_cmd o_data,
    output logic o_full,
    output logic o_empty
);

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);

    t_cmd            r_mem [DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [PW:0]     r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wp] <= i_data;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push)
                r_wp <= r_wp + 1'b1;
            if (i_pop)
                r_rp <= r_rp + 1'b1;
            if (i_push && !i_pop)
                r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop)
                r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

// ===== hw/rtl/tcw_back.sv =====
module tcw_back
    import tcw_pkg::*;
#(
    parameter int MAX_COLS = 80,
    parameter int MAX_ROWS = 25,
    parameter int TAB_STOP = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [COL_W-1:0]     i_cfg_data,
    input  logic                 i_empty,
    input  t_cmd                 i_cmd,
    output logic                 o_pop,
    output logic                 o_valid,
    output logic [COL_W-1:0]     o_cursor_col,
    output logic [ROW_W-1:0]     o_cursor_row,
    output logic [OUT_LIN_W-1:0] o_cursor_linear,
    output logic [7:0]           o_read_char,
    output logic [7:0]           o_read_attr,
    output logic [7:0]           o_current_attr
);

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int W_RST = (80 > MAX_COLS) ? MAX_COLS : 80;
    localparam int H_RST = (25 > MAX_ROWS) ? MAX_ROWS : 25;
    localparam int TBL_N = 1 << COL_W;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_ADDR   = 11'b000_0000_0010,
        S_WRITE  = 11'b000_0000_0100,
        S_SETTLE = 11'b000_0000_1000,
        S_RD     = 11'b000_0001_0000,
        S_RDW    = 11'b000_0010_0000,
        S_SCR_RD = 11'b000_0100_0000,
        S_SCR_WR = 11'b000_1000_0000,
        S_CLR    = 11'b001_0000_0000,
        S_FIN    = 11'b010_0000_0000,
        S_SPARE  = 11'b100_0000_0000
    } t_bstate;

    t_bstate          r_state;
    t_cmd             r_cmd;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_width;
    logic [ROW_W-1:0] r_height;
    logic [LIN_W-1:0] r_total;
    logic [LIN_W-1:0] r_lin;
    logic [LIN_W-1:0] r_ptr;
    logic [7:0]       r_rchar;
    logic [7:0]       r_rattr;
    logic [15:0]      r_rdata;
    logic [15:0]      r_cells [DEPTH];

    logic                 r_valid;
    logic [COL_W-1:0]     r_out_col;
    logic [ROW_W-1:0]     r_out_row;
    logic [OUT_LIN_W-1:0] r_out_lin;
    logic [7:0]           r_out_rchar;
    logic [7:0]           r_out_rattr;
    logic [7:0]           r_out_attr;

    logic [TBL_N-1:0] tab_tbl;
    logic [ROW_W-1:0] m_row;
    logic [COL_W-1:0] m_col;
    logic [LIN_W-1:0] mul_lin;
    logic             col_wrap;
    logic [COL_W-1:0] s_col;
    logic [ROW_W-1:0] s_row;
    logic             s_scroll;
    logic [LIN_W-1:0] src_ptr;
    logic             copy_ok;
    logic             mem_we;
    logic [AW-1:0]    mem_wa;
    logic [AW-1:0]    mem_ra;
    logic [15:0]      mem_wd;
    logic [7:0]       wr_ch;
    logic [COL_W-1:0] cfg_w;
    logic [ROW_W-1:0] cfg_h;
    logic             rd_in_range;

    // constant table of columns that sit on a tab stop
    always_comb begin
        for (int i = 0; i < TBL_N; i++)
            tab_tbl[i] = ((i % TAB_STOP) == 0);
    end

    // shared row times width plus column
    always_comb begin
        if (r_state == S_ADDR && r_cmd.op == OP_READ) begin
            m_row = r_cmd.row;
            m_col = r_cmd.col;
        end else begin
            m_row = r_row;
            m_col = r_col;
        end
    end
    assign mul_lin = LIN_W'({7'd0, m_row} * {5'd0, r_width}) + {5'd0, m_col};

    // cursor settle after an advance: wrap the column, then check for scroll
    assign col_wrap = (r_col >= r_width);
    assign s_col    = col_wrap ? '0 : r_col;
    assign s_row    = col_wrap ? r_row + 1'b1 : r_row;
    assign s_scroll = (s_row >= r_height);

    // scroll sweep: copy from one line below until the last line, then blank
    assign src_ptr = r_ptr + {5'd0, r_width};
    assign copy_ok = (src_ptr < r_total);

    assign wr_ch       = (r_cmd.op == OP_TAB) ? CH_SPACE : r_cmd.ch;
    assign rd_in_range = (i_cmd.col < r_width) && (i_cmd.row < r_height);
    assign o_pop       = (r_state == S_IDLE) && !i_empty;

    // configuration value limits
    always_comb begin
        cfg_w = i_cfg_data;
        if (cfg_w == '0)
            cfg_w = COL_W'(1);
        else if (int'(cfg_w) > MAX_COLS)
            cfg_w = COL_W'(MAX_COLS);
        cfg_h = i_cfg_data[ROW_W-1:0];
        if (cfg_h == '0)
            cfg_h = ROW_W'(1);
        else if (int'(cfg_h) > MAX_ROWS)
            cfg_h = ROW_W'(MAX_ROWS);
    end

    // cell store port selection
    always_comb begin
        mem_we = 1'b0;
        mem_wa = AW'(r_ptr);
        mem_wd = CELL_BLANK;
        mem_ra = AW'(r_lin);
        case (r_state)
            S_WRITE: begin
                mem_we = 1'b1;
                mem_wa = AW'(r_lin);
                mem_wd = {r_cmd.attr, wr_ch};
            end
            S_SCR_RD: begin
                mem_ra = AW'(src_ptr);
                mem_we = !copy_ok;
            end
            S_SCR_WR: begin
                mem_we = 1'b1;
                mem_wd = r_rdata;
            end
            S_CLR:   mem_we = 1'b1;
            default: mem_we = 1'b0;
        endcase
    end

    // cell store
    always_ff @(posedge i_clk) begin
        if (mem_we)
            r_cells[mem_wa] <= mem_wd;
        r_rdata <= r_cells[mem_ra];
    end

    // screen size product for sweeps
    always_ff @(posedge i_clk) begin
        r_total <= LIN_W'({7'd0, r_height} * {5'd0, r_width});
    end

    // sequencer for one word at a time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_col    <= '0;
            r_row    <= '0;
            r_width  <= COL_W'(W_RST);
            r_height <= ROW_W'(H_RST);
            r_valid  <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_cmd   <= i_cmd;
                        r_rchar <= 8'd0;
                        r_rattr <= 8'd0;
                        r_ptr   <= '0;
                        case (i_cmd.op)
                            OP_CR: begin
                                r_col   <= '0;
                                r_state <= S_FIN;
                            end
                            OP_NEWLINE: begin
                                r_col   <= '0;
                                r_row   <= r_row + 1'b1;
                                r_state <= S_SETTLE;
                            end
                            OP_PRINT, OP_TAB: r_state <= S_ADDR;
                            OP_READ:  r_state <= rd_in_range ? S_ADDR : S_FIN;
                            OP_CLEAR: r_state <= S_CLR;
                            default:  r_state <= S_FIN;
                        endcase
                    end
                end
                S_ADDR: begin
                    r_lin   <= mul_lin;
                    r_state <= (r_cmd.op == OP_READ) ? S_RD : S_WRITE;
                end
                S_WRITE: begin
                    r_col   <= r_col + 1'b1;
                    r_state <= S_SETTLE;
                end
                S_SETTLE: begin
                    r_col <= s_col;
                    if (s_scroll) begin
                        r_row   <= r_height - 1'b1;
                        r_ptr   <= '0;
                        r_state <= S_SCR_RD;
                    end else begin
                        r_row   <= s_row;
                        r_state <= (r_cmd.op == OP_TAB && !tab_tbl[s_col]) ? S_ADDR : S_FIN;
                    end
                end
                S_RD:  r_state <= S_RDW;
                S_RDW: begin
                    r_rchar <= r_rdata[7:0];
                    r_rattr <= r_rdata[15:8];
                    r_state <= S_FIN;
                end
                S_SCR_RD: begin
                    if (copy_ok) begin
                        r_state <= S_SCR_WR;
                    end else if (r_ptr == r_total - 1'b1) begin
                        r_state <= (r_cmd.op == OP_TAB && !tab_tbl[r_col]) ? S_ADDR : S_FIN;
                    end else begin
                        r_ptr <= r_ptr + 1'b1;
                    end
                end
                S_SCR_WR: begin
                    r_ptr   <= r_ptr + 1'b1;
                    r_state <= S_SCR_RD;
                end
                S_CLR: begin
                    if (r_ptr == r_total - 1'b1) begin
                        r_col   <= '0;
                        r_row   <= '0;
                        r_state <= S_FIN;
                    end else begin
                        r_ptr <= r_ptr + 1'b1;
                    end
                end
                S_FIN: begin
                    r_out_col   <= r_col;
                    r_out_row   <= r_row;
                    r_out_lin   <= mul_lin[OUT_LIN_W-1:0];
                    r_out_rchar <= r_rchar;
                    r_out_rattr <= r_rattr;
                    r_out_attr  <= r_cmd.attr;
                    r_valid     <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase

            // register writes, to be made only while idle (not enforced here); cursor kept on screen
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_WIDTH: begin
                        r_width <= cfg_w;
                        if (r_col >= cfg_w)
                            r_col <= cfg_w - 1'b1;
                    end
                    CFG_HEIGHT: begin
                        r_height <= cfg_h;
                        if (r_row >= cfg_h)
                            r_row <= cfg_h - 1'b1;
                    end
                    default: r_width <= r_width;
                endcase
            end
        end
    end

    assign o_valid         = r_valid;
    assign o_cursor_col    = r_out_col;
    assign o_cursor_row    = r_out_row;
    assign o_cursor_linear = r_out_lin;
    assign o_read_char     = r_out_rchar;
    assign o_read_attr     = r_out_rattr;
    assign o_current_attr  = r_out_attr;

endmodule

// ===== hw/rtl/text_console_writer_ansi_color.sv =====
// Text console with ANSI color escapes over a character/attribute cell store.
// Requests: raise start with i_req_type and its fields; the word is taken at
// an edge where start is high and busy is low. Write requests carry a console
// byte, read requests a cell position, clear requests nothing.
// Every request gives one result: o_valid is high for exactly one cycle with
// the cursor, the read cell (zero unless a read) and the current attribute.
// The receiver cannot stall; each result must be taken in its cycle.
// A front parser classifies bytes and tracks the escape state and color,
// then a two-word queue feeds the back sequencer that owns the cell store.
// busy is high only while that queue is full, so up to two words wait.
// From acceptance to the result: a carriage return, an escape byte, an unused code
// or a read off the screen go straight to the result state; a newline passes the
// settle state, a printed byte the address, write and settle states, a read the
// address and read states; each extra tab space repeats address, write and settle.
// The back end works on one word at a time. A scroll copies each cell with a read
// state and a write state, then blanks the last line; clear blanks every cell.
// Register writes on i_cfg_* take effect at once; the user is to make them only
// while idle, which the block does not enforce.
// Reset homes the cursor, sets attribute 0x07 and 80x25 (or MAX_COLS x MAX_ROWS
// if smaller); cells stay undefined until written.
module text_console_writer_ansi_color
    import tcw_pkg::*;
#(
    parameter int MAX_COLS = 80,
    parameter int MAX_ROWS = 25,
    parameter int TAB_STOP = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           i_req_type,
    input  logic [7:0]           i_data_byte,
    input  logic [COL_W-1:0]     i_cell_col,
    input  logic [ROW_W-1:0]     i_cell_row,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [COL_W-1:0]     i_cfg_data,
    output logic                 o_valid,
    output logic [COL_W-1:0]     o_cursor_col,
    output logic [ROW_W-1:0]     o_cursor_row,
    output logic [OUT_LIN_W-1:0] o_cursor_linear,
    output logic [7:0]           o_read_char,
    output logic [7:0]           o_read_attr,
    output logic [7:0]           o_current_attr
);

    logic push;
    logic pop;
    logic full;
    logic empty;
    t_cmd push_cmd;
    t_cmd pop_cmd;

    assign busy = full;

    // byte parser and classifier
    tcw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_full      (full),
        .i_req_type  (i_req_type),
        .i_data_byte (i_data_byte),
        .i_cell_col  (i_cell_col),
        .i_cell_row  (i_cell_row),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    // command queue
    tcw_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .i_pop   (pop),
        .o_data  (pop_cmd),
        .o_full  (full),
        .o_empty (empty)
    );

    // cell store sequencer
    tcw_back #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_empty         (empty),
        .i_cmd           (pop_cmd),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .o_cursor_col    (o_cursor_col),
        .o_cursor_row    (o_cursor_row),
        .o_cursor_linear (o_cursor_linear),
        .o_read_char     (o_read_char),
        .o_read_attr     (o_read_attr),
        .o_current_attr  (o_current_attr)
    );

endmodule
